>>> rtl/arxc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arxc_pkg
// Shared types, register indexes and round helpers for the 4x32 ARX cipher.
// ----------------------------------------------------------------------------
package arxc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_W  = 64;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned NUM_KEY_REGS = 6;

    localparam int unsigned ROT_A = 2;
    localparam int unsigned ROT_C = 4;
    localparam int unsigned ROT_B = 8;
    localparam int unsigned ROT_D = 16;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CFG_W-1:0]  cfg_data_t;
    typedef logic [IDX_W-1:0]  cfg_idx_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } block_t;

    // per-stage control
    typedef struct packed {
        logic second_half;
        logic bypass;
    } stage_ctl_t;

    localparam cfg_idx_t CFG_MODE     = 3'd0;
    localparam cfg_idx_t CFG_KEY_0_1  = 3'd1;
    localparam cfg_idx_t CFG_KEY_2_3  = 3'd2;
    localparam cfg_idx_t CFG_KEY_4_5  = 3'd3;
    localparam cfg_idx_t CFG_KEY_6_7  = 3'd4;
    localparam cfg_idx_t CFG_KEY_8_9  = 3'd5;
    localparam cfg_idx_t CFG_KEY_10_11 = 3'd6;

    function automatic word_t rotl32(word_t x, int unsigned n);
        rotl32 = (x << n) | (x >> (WORD_W - n));
    endfunction

    // a += b, a ^= d, c += d, c ^= b, rotate a and c
    function automatic block_t half_round_ac(block_t x);
        word_t a;
        word_t c;
        a = (x.a + x.b) ^ x.d;
        c = (x.c + x.d) ^ x.b;
        half_round_ac = '{a: rotl32(a, ROT_A), b: x.b, c: rotl32(c, ROT_C), d: x.d};
    endfunction

    // b += c, b ^= a, d += a, d ^= c, rotate b and d
    function automatic block_t half_round_bd(block_t x);
        word_t b;
        word_t d;
        b = (x.b + x.c) ^ x.a;
        d = (x.d + x.a) ^ x.c;
        half_round_bd = '{a: x.a, b: rotl32(b, ROT_B), c: x.c, d: rotl32(d, ROT_D)};
    endfunction

endpackage

>>> rtl/arxc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arxc_in_if / arxc_out_if
// Valid/ready channels carrying one 128-bit block (four 32-bit words) per transfer.
// ----------------------------------------------------------------------------
interface arxc_in_if import arxc_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t in_word_a;
    word_t in_word_b;
    word_t in_word_c;
    word_t in_word_d;

    modport source (output valid, output in_word_a, output in_word_b,
                    output in_word_c, output in_word_d, input ready);
    modport sink   (input valid, input in_word_a, input in_word_b,
                    input in_word_c, input in_word_d, output ready);
endinterface

interface arxc_out_if import arxc_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t out_word_a;
    word_t out_word_b;
    word_t out_word_c;
    word_t out_word_d;

    modport source (output valid, output out_word_a, output out_word_b,
                    output out_word_c, output out_word_d, input ready);
    modport sink   (input valid, input out_word_a, input out_word_b,
                    input out_word_c, input out_word_d, output ready);
endinterface

>>> rtl/arxc_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arxc_stage
// One pipeline stage: optional key XOR, one half round or bypass, register.
// ----------------------------------------------------------------------------
module arxc_stage import arxc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  block_t     key,
    input  logic       up_valid,
    input  block_t     up_blk,
    output logic       up_ready,
    output logic       down_valid,
    output block_t     down_blk,
    input  logic       down_ready
);

    logic   valid_reg;
    block_t blk_reg;
    block_t mixed;
    block_t blk_next;

    always_comb
    begin
        mixed = up_blk ^ key;
        if (ctl.bypass)
        begin
            blk_next = mixed;
        end
        else if (ctl.second_half)
        begin
            blk_next = half_round_bd(mixed);
        end
        else
        begin
            blk_next = half_round_ac(mixed);
        end
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            blk_reg <= blk_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_blk   = blk_reg;

endmodule

>>> rtl/arx_block_cipher_4x32_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arx_block_cipher_4x32_core
// Pipelined 4x32 ARX block cipher, keyed (three whitening keys) or bare.
//
//  channel   dir  handshake       payload
//  req       in   valid/ready     in_word_a..in_word_d (4 x 32)
//  rsp       out  valid/ready     out_word_a..out_word_d (4 x 32)
//  cfg       in   cfg_we          cfg_index (3), cfg_data (64)
//
// One stage per half round plus the final key stage. One word accepted
// per cycle unless every stage is full and rsp stalls.
// Each stage holds its word until taken; empty stages fill while rsp stalls.
// Reset clears all valid bits, sets keyed mode and zeroes the keys.
// ----------------------------------------------------------------------------
module arx_block_cipher_4x32_core import arxc_pkg::*;
#(
    parameter int unsigned ROUNDS_PER_HALF = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_data,
    arxc_in_if.sink   req,
    arxc_out_if.source rsp
);

    localparam int unsigned HALF_STAGES = 2 * ROUNDS_PER_HALF;
    localparam int unsigned NUM_STAGES  = 2 * HALF_STAGES + 1;
    localparam int unsigned OCC_W       = $clog2(NUM_STAGES + 1);

    logic      mode_reg;
    cfg_data_t key_reg [NUM_KEY_REGS];

    logic   stg_valid [NUM_STAGES+1];
    logic   stg_ready [NUM_STAGES+1];
    block_t stg_blk   [NUM_STAGES+1];
    logic [NUM_STAGES-1:0] valid_vec;

    block_t rk0;
    block_t rk1;
    block_t rk2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
            for (int i = 0; i < NUM_KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:      mode_reg   <= cfg_data[0];
                CFG_KEY_0_1:   key_reg[0] <= cfg_data;
                CFG_KEY_2_3:   key_reg[1] <= cfg_data;
                CFG_KEY_4_5:   key_reg[2] <= cfg_data;
                CFG_KEY_6_7:   key_reg[3] <= cfg_data;
                CFG_KEY_8_9:   key_reg[4] <= cfg_data;
                CFG_KEY_10_11: key_reg[5] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // round key n = key words 4n..4n+3 on a, b, c, d
    assign rk0 = '{a: key_reg[0][31:0], b: key_reg[0][63:32],
                   c: key_reg[1][31:0], d: key_reg[1][63:32]};
    assign rk1 = '{a: key_reg[2][31:0], b: key_reg[2][63:32],
                   c: key_reg[3][31:0], d: key_reg[3][63:32]};
    assign rk2 = '{a: key_reg[4][31:0], b: key_reg[4][63:32],
                   c: key_reg[5][31:0], d: key_reg[5][63:32]};

    assign stg_valid[0] = req.valid;
    assign stg_blk[0]   = '{a: req.in_word_a, b: req.in_word_b,
                            c: req.in_word_c, d: req.in_word_d};
    assign req.ready    = stg_ready[0];

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        stage_ctl_t ctl;
        block_t     key;

        always_comb
        begin
            ctl.second_half = (s % 2) == 1;
            if (s == NUM_STAGES - 1)
            begin
                ctl.bypass = 1'b1;
            end
            else
            begin
                ctl.bypass = (s >= HALF_STAGES) && !mode_reg;
            end

            if (!mode_reg)
            begin
                key = '0;
            end
            else if (s == 0)
            begin
                key = rk0;
            end
            else if (s == HALF_STAGES)
            begin
                key = rk1;
            end
            else if (s == NUM_STAGES - 1)
            begin
                key = rk2;
            end
            else
            begin
                key = '0;
            end
        end

        arxc_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key        (key),
            .up_valid   (stg_valid[s]),
            .up_blk     (stg_blk[s]),
            .up_ready   (stg_ready[s]),
            .down_valid (stg_valid[s+1]),
            .down_blk   (stg_blk[s+1]),
            .down_ready (stg_ready[s+1])
        );

        assign valid_vec[s] = stg_valid[s+1];
    end

    assign stg_ready[NUM_STAGES] = rsp.ready;
    assign rsp.valid      = stg_valid[NUM_STAGES];
    assign rsp.out_word_a = stg_blk[NUM_STAGES].a;
    assign rsp.out_word_b = stg_blk[NUM_STAGES].b;
    assign rsp.out_word_c = stg_blk[NUM_STAGES].c;
    assign rsp.out_word_d = stg_blk[NUM_STAGES].d;

    // words in flight
    logic             in_acc;
    logic             out_acc;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign in_acc   = req.valid && req.ready;
    assign out_acc  = rsp.valid && rsp.ready;
    assign occ_next = occ_reg + OCC_W'(in_acc) - OCC_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        OCC_W'($countones(valid_vec)) == occ_reg)
        else $error("stage valid bits disagree with words in flight");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (&valid_vec))
        else $error("input stalled with an empty stage");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> valid_vec[0])
        else $error("accepted word missing from first stage");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid)
        else $error("stalled result lost");

endmodule
